/* hdl/ilm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt latency monitor package
// Shared constants, codes and control structs for the monitor and its units.
// ----------------------------------------------------------------------------
package ilm_pkg;

  // Field widths.
  localparam int unsigned TICK_RATE_W = 40;
  localparam int unsigned PTR_BYTES_W = 4;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned END_W       = 63;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned US_W        = 40;
  localparam int unsigned PROD_W      = 96;
  localparam int unsigned DEN_W       = 72;
  localparam int unsigned MPLIER_W    = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  // Item kinds.
  localparam logic [1:0] KIND_LATENCY = 2'd0;
  localparam logic [1:0] KIND_IMAGE   = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  // Accepted opcodes.
  localparam logic [7:0] OPC_LAT_LO   = 8'd66;
  localparam logic [7:0] OPC_LAT_HI   = 8'd69;
  localparam logic [7:0] OPC_IMG_LOAD = 8'd10;
  localparam logic [7:0] OPC_IMG_A    = 8'd3;
  localparam logic [7:0] OPC_IMG_B    = 8'd4;

  // Microseconds in Q.8 per second: 1e6 * 256.
  localparam logic [27:0] US_Q8_SCALE = 28'd256000000;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PTR_BYTES = 2'd1;
  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = 40'd10000000;
  localparam logic [PTR_BYTES_W-1:0] PTR_BYTES_RST = 4'd8;

  // Operation codes of the shared arithmetic unit.
  typedef enum logic [1:0] {
    MD_MUL = 2'b01,
    MD_DIV = 2'b10
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

/* hdl/ilm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt latency monitor channels
// Valid/ready channels for event items and statistics result items.
// ----------------------------------------------------------------------------
interface ilm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  opcode;
  logic [15:0] payload_length;
  logic [63:0] start_time;
  logic [62:0] end_time;
  logic [63:0] routine_addr;
  logic [63:0] image_base;
  logic [63:0] image_size;

  modport source (
    output valid, kind, opcode, payload_length, start_time, end_time,
           routine_addr, image_base, image_size,
    input  ready
  );
  modport sink (
    input  valid, kind, opcode, payload_length, start_time, end_time,
           routine_addr, image_base, image_size,
    output ready
  );
endinterface

interface ilm_out_if;
  logic        valid;
  logic        ready;
  logic        available;
  logic [39:0] lat_max;
  logic [39:0] lat_avg;
  logic        driver_found;
  logic [7:0]  driver_index;
  logic        images_dropped;

  modport source (
    output valid, available, lat_max, lat_avg, driver_found,
           driver_index, images_dropped,
    input  ready
  );
  modport sink (
    input  valid, available, lat_max, lat_avg, driver_found,
           driver_index, images_dropped,
    output ready
  );
endinterface

/* hdl/ilm_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply/divide unit
// Shift-add multiplier and restoring divider around one 96-bit adder.
// ----------------------------------------------------------------------------
module ilm_muldiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ilm_pkg::md_req_t             req,
  input  logic [63:0]                  mcand_i,
  input  logic [ilm_pkg::MPLIER_W-1:0] mplier_i,
  input  logic [ilm_pkg::PROD_W-1:0]   num_i,
  input  logic [ilm_pkg::DEN_W-1:0]    den_i,
  output ilm_pkg::md_rsp_t             rsp,
  output logic [ilm_pkg::PROD_W-1:0]   prod_o,
  output logic [ilm_pkg::US_W-1:0]     quot_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } md_state_t;

  md_state_t                      state_r, state_nxt;
  logic [5:0]                     step_r, step_nxt;
  logic [ilm_pkg::PROD_W-1:0]     acc_r, acc_nxt;
  logic [ilm_pkg::PROD_W-1:0]     opb_r, opb_nxt;
  logic [ilm_pkg::MPLIER_W-1:0]   mplier_r, mplier_nxt;
  logic [ilm_pkg::US_W-1:0]       quot_r, quot_nxt;
  logic                           sat_r, sat_nxt;
  logic                           done_r, done_nxt;
  logic [ilm_pkg::PROD_W-1:0]     opa;
  logic [ilm_pkg::PROD_W-1:0]     addend;
  logic [ilm_pkg::PROD_W:0]       sum;
  logic [ilm_pkg::PROD_W-1:0]     trial;

  // One adder: accumulate in multiply, trial subtract in divide.
  always_comb begin
    trial  = {acc_r[ilm_pkg::PROD_W-2:0], quot_r[ilm_pkg::US_W-1]};
    opa    = (state_r == S_DIV) ? trial : acc_r;
    addend = (state_r == S_DIV) ? ~opb_r : opb_r;
    sum    = {1'b0, opa} + {1'b0, addend} + {{ilm_pkg::PROD_W{1'b0}}, (state_r == S_DIV)};
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    opb_nxt    = opb_r;
    mplier_nxt = mplier_r;
    quot_nxt   = quot_r;
    sat_nxt    = sat_r;
    done_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (req.start && req.op == ilm_pkg::MD_MUL) begin
          acc_nxt    = '0;
          opb_nxt    = {32'd0, mcand_i};
          mplier_nxt = mplier_i;
          step_nxt   = 6'd32;
          state_nxt  = S_MUL;
        end else if (req.start && req.op == ilm_pkg::MD_DIV) begin
          // The quotient saturates when the top part already reaches the divisor.
          acc_nxt   = {40'd0, num_i[ilm_pkg::PROD_W-1:ilm_pkg::US_W]};
          opb_nxt   = {24'd0, den_i};
          quot_nxt  = num_i[ilm_pkg::US_W-1:0];
          sat_nxt   = ({40'd0, num_i[ilm_pkg::PROD_W-1:ilm_pkg::US_W]} >= {24'd0, den_i});
          step_nxt  = 6'd40;
          state_nxt = S_DIV;
        end
      end
      S_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = sum[ilm_pkg::PROD_W-1:0];
        end
        opb_nxt    = {opb_r[ilm_pkg::PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[ilm_pkg::MPLIER_W-1:1]};
        step_nxt   = step_r - 6'd1;
        if (step_r == 6'd1) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        // Carry out set means the trial remainder reached the divisor.
        acc_nxt  = sum[ilm_pkg::PROD_W] ? sum[ilm_pkg::PROD_W-1:0] : trial;
        quot_nxt = {quot_r[ilm_pkg::US_W-2:0], sum[ilm_pkg::PROD_W]};
        step_nxt = step_r - 6'd1;
        if (step_r == 6'd1) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    opb_r    <= opb_nxt;
    mplier_r <= mplier_nxt;
    quot_r   <= quot_nxt;
    sat_r    <= sat_nxt;
  end

  assign rsp.busy = (state_r != S_IDLE);
  assign rsp.done = done_r;
  assign prod_o   = acc_r;
  assign quot_o   = sat_r ? {ilm_pkg::US_W{1'b1}} : quot_r;

endmodule

/* hdl/ilm_image_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image range table
// Stores image base and size per slot and tests a slot against an address.
// ----------------------------------------------------------------------------
module ilm_image_table #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wbase,
  input  logic [63:0]   wsize,
  input  logic [AW-1:0] raddr,
  input  logic [63:0]   worst_addr,
  output logic          hit
);

  logic [63:0] base_mem [SLOTS];
  logic [63:0] size_mem [SLOTS];
  logic [63:0] base_r;
  logic [63:0] size_r;
  logic [63:0] offset;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      base_mem[waddr] <= wbase;
      size_mem[waddr] <= wsize;
    end
    base_r <= base_mem[raddr];
    size_r <= size_mem[raddr];
  end

  // The range holds the address when it lies in [base, base + size).
  always_comb begin
    offset = worst_addr - base_r;
    hit    = (size_r != 64'd0) && (worst_addr >= base_r) && (offset < size_r);
  end

endmodule

/* hdl/interrupt_latency_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt latency monitor
// Accumulates routine latencies and image ranges, answers statistics queries.
// ----------------------------------------------------------------------------
// Latency and image events are taken in the idle state and produce no result. A
// query runs its arithmetic on one shared multiply/divide unit: each multiply or
// divide holds the sequencer through launch, its 32 or 40 steps and hand-back,
// three multiplies and two divides with events counted (one of each otherwise,
// none at zero tick rate). It then walks the image table up to the first match,
// with a read state and a check state per entry, since the table memory has one
// registered read port. The block takes no item while a query runs. A result
// waits in the output register; a later query holds in its last state until
// that result is taken.
module interrupt_latency_monitor #(
  parameter int unsigned IMAGE_SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ilm_in_if.sink                          in_ch,
  ilm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ilm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilm_pkg::TICK_RATE_W-1:0] cfg_data
);

  localparam int unsigned AW = (IMAGE_SLOTS > 1) ? $clog2(IMAGE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(IMAGE_SLOTS + 1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MAX_MUL  = 9'b000000010,
    ST_MAX_DIV  = 9'b000000100,
    ST_SUM_MUL  = 9'b000001000,
    ST_DEN_MUL  = 9'b000010000,
    ST_AVG_DIV  = 9'b000100000,
    ST_SCAN_RD  = 9'b001000000,
    ST_SCAN_CHK = 9'b010000000,
    ST_DONE     = 9'b100000000
  } ilm_state_t;

  ilm_state_t                        state_r, state_nxt;
  logic [ilm_pkg::TICK_RATE_W-1:0]   tick_rate_r;
  logic [ilm_pkg::PTR_BYTES_W-1:0]   ptr_bytes_r;
  logic [63:0]                       tick_sum_r, tick_sum_nxt;
  logic [ilm_pkg::COUNT_W-1:0]       event_count_r, event_count_nxt;
  logic [63:0]                       max_ticks_r, max_ticks_nxt;
  logic [63:0]                       worst_addr_r, worst_addr_nxt;
  logic [CW-1:0]                     range_count_r, range_count_nxt;
  logic                              overflow_r, overflow_nxt;
  logic                              launched_r, launched_nxt;
  logic [ilm_pkg::PROD_W-1:0]        num_r, num_nxt;
  logic [ilm_pkg::DEN_W-1:0]         den_r, den_nxt;
  logic [ilm_pkg::US_W-1:0]          max_us_r, max_us_nxt;
  logic [ilm_pkg::US_W-1:0]          avg_us_r, avg_us_nxt;
  logic [CW-1:0]                     scan_idx_r, scan_idx_nxt;
  logic                              found_r, found_nxt;
  logic [7:0]                        index_r, index_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_avail_r, out_avail_nxt;
  logic [ilm_pkg::US_W-1:0]          out_max_r, out_max_nxt;
  logic [ilm_pkg::US_W-1:0]          out_avg_r, out_avg_nxt;
  logic                              out_found_r, out_found_nxt;
  logic [7:0]                        out_index_r, out_index_nxt;
  logic                              out_drop_r, out_drop_nxt;

  logic                              accept;
  logic                              wide_ptr;
  logic                              lat_ok;
  logic                              img_ok;
  logic                              table_full;
  logic [63:0]                       ticks;
  logic [64:0]                       sum_ext;
  logic                              tbl_we;
  logic                              tbl_hit;
  logic [CW-1:0]                     scan_next;
  ilm_pkg::md_req_t                  md_req;
  ilm_pkg::md_rsp_t                  md_rsp;
  logic [63:0]                       md_mcand;
  logic [ilm_pkg::MPLIER_W-1:0]      md_mplier;
  logic [ilm_pkg::DEN_W-1:0]         md_den;
  logic [ilm_pkg::PROD_W-1:0]        md_prod;
  logic [ilm_pkg::US_W-1:0]          md_quot;

  assign accept   = in_ch.valid && in_ch.ready;
  assign wide_ptr = (ptr_bytes_r >= 4'd8);

  // Event filters and latency arithmetic.
  always_comb begin
    lat_ok = (in_ch.opcode >= ilm_pkg::OPC_LAT_LO) && (in_ch.opcode <= ilm_pkg::OPC_LAT_HI)
          && (in_ch.payload_length >= (16'd8 + {12'd0, ptr_bytes_r}))
          && (tick_rate_r != '0) && (in_ch.start_time != 64'd0)
          && ({1'b0, in_ch.end_time} >= in_ch.start_time);
    img_ok = ((in_ch.opcode == ilm_pkg::OPC_IMG_LOAD) || (in_ch.opcode == ilm_pkg::OPC_IMG_A)
          || (in_ch.opcode == ilm_pkg::OPC_IMG_B))
          && (in_ch.payload_length >= {11'd0, ptr_bytes_r, 1'b0});
    table_full = (range_count_r >= CW'(IMAGE_SLOTS));
    ticks      = {1'b0, in_ch.end_time} - in_ch.start_time;
    sum_ext    = {1'b0, tick_sum_r} + {1'b0, ticks};
    tbl_we     = accept && (state_r == ST_IDLE) && (in_ch.kind == ilm_pkg::KIND_IMAGE)
              && img_ok && !table_full;
  end

  // Operand selection for the shared unit.
  always_comb begin
    md_req.start = !launched_r && ((state_r == ST_MAX_MUL) || (state_r == ST_MAX_DIV)
                || (state_r == ST_SUM_MUL) || (state_r == ST_DEN_MUL)
                || (state_r == ST_AVG_DIV));
    md_req.op    = ((state_r == ST_MAX_DIV) || (state_r == ST_AVG_DIV))
                 ? ilm_pkg::MD_DIV : ilm_pkg::MD_MUL;
    case (state_r)
      ST_MAX_MUL: md_mcand = max_ticks_r;
      ST_SUM_MUL: md_mcand = tick_sum_r;
      default:    md_mcand = {24'd0, tick_rate_r};
    endcase
    md_mplier = (state_r == ST_DEN_MUL) ? event_count_r : {4'd0, ilm_pkg::US_Q8_SCALE};
    md_den    = (state_r == ST_MAX_DIV) ? {32'd0, tick_rate_r} : den_r;
  end

  ilm_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (md_req),
    .mcand_i  (md_mcand),
    .mplier_i (md_mplier),
    .num_i    (num_r),
    .den_i    (md_den),
    .rsp      (md_rsp),
    .prod_o   (md_prod),
    .quot_o   (md_quot)
  );

  ilm_image_table #(
    .SLOTS (IMAGE_SLOTS),
    .AW    (AW)
  ) u_table (
    .clk        (clk),
    .we         (tbl_we),
    .waddr      (range_count_r[AW-1:0]),
    .wbase      (wide_ptr ? in_ch.image_base : {32'd0, in_ch.image_base[31:0]}),
    .wsize      (wide_ptr ? in_ch.image_size : {32'd0, in_ch.image_size[31:0]}),
    .raddr      (scan_idx_r[AW-1:0]),
    .worst_addr (worst_addr_r),
    .hit        (tbl_hit)
  );

  assign scan_next = scan_idx_r + CW'(1);

  // Main sequencer: events, query arithmetic, table walk, result hand-off.
  always_comb begin
    state_nxt       = state_r;
    tick_sum_nxt    = tick_sum_r;
    event_count_nxt = event_count_r;
    max_ticks_nxt   = max_ticks_r;
    worst_addr_nxt  = worst_addr_r;
    range_count_nxt = range_count_r;
    overflow_nxt    = overflow_r;
    launched_nxt    = launched_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    max_us_nxt      = max_us_r;
    avg_us_nxt      = avg_us_r;
    scan_idx_nxt    = scan_idx_r;
    found_nxt       = found_r;
    index_nxt       = index_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_avail_nxt   = out_avail_r;
    out_max_nxt     = out_max_r;
    out_avg_nxt     = out_avg_r;
    out_found_nxt   = out_found_r;
    out_index_nxt   = out_index_r;
    out_drop_nxt    = out_drop_r;
    if (md_req.start) begin
      launched_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.kind == ilm_pkg::KIND_LATENCY && lat_ok) begin
          tick_sum_nxt = sum_ext[64] ? {64{1'b1}} : sum_ext[63:0];
          if (event_count_r != {ilm_pkg::COUNT_W{1'b1}}) begin
            event_count_nxt = event_count_r + 32'd1;
          end
          if (ticks > max_ticks_r) begin
            max_ticks_nxt  = ticks;
            worst_addr_nxt = wide_ptr ? in_ch.routine_addr
                                      : {32'd0, in_ch.routine_addr[31:0]};
          end
        end else if (accept && in_ch.kind == ilm_pkg::KIND_IMAGE && img_ok) begin
          if (table_full) begin
            overflow_nxt = 1'b1;
          end else begin
            range_count_nxt = range_count_r + CW'(1);
          end
        end else if (accept && in_ch.kind == ilm_pkg::KIND_QUERY) begin
          max_us_nxt   = '0;
          avg_us_nxt   = '0;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          index_nxt    = 8'd0;
          if (tick_rate_r != '0) begin
            state_nxt = ST_MAX_MUL;
          end else if (worst_addr_r != 64'd0 && range_count_r != '0) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MAX_MUL: begin
        if (md_rsp.done) begin
          num_nxt      = md_prod;
          launched_nxt = 1'b0;
          state_nxt    = ST_MAX_DIV;
        end
      end
      ST_MAX_DIV: begin
        if (md_rsp.done) begin
          max_us_nxt   = md_quot;
          launched_nxt = 1'b0;
          if (event_count_r != '0) begin
            state_nxt = ST_SUM_MUL;
          end else if (worst_addr_r != 64'd0 && range_count_r != '0) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SUM_MUL: begin
        if (md_rsp.done) begin
          num_nxt      = md_prod;
          launched_nxt = 1'b0;
          state_nxt    = ST_DEN_MUL;
        end
      end
      ST_DEN_MUL: begin
        if (md_rsp.done) begin
          den_nxt      = md_prod[ilm_pkg::DEN_W-1:0];
          launched_nxt = 1'b0;
          state_nxt    = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        if (md_rsp.done) begin
          avg_us_nxt   = md_quot;
          launched_nxt = 1'b0;
          if (worst_addr_r != 64'd0 && range_count_r != '0) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (tbl_hit) begin
          found_nxt = 1'b1;
          index_nxt = 8'(scan_idx_r);
          state_nxt = ST_DONE;
        end else if (scan_next == range_count_r) begin
          state_nxt = ST_DONE;
        end else begin
          scan_idx_nxt = scan_next;
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_avail_nxt = (event_count_r != '0);
          out_max_nxt   = max_us_r;
          out_avg_nxt   = avg_us_r;
          out_found_nxt = found_r;
          out_index_nxt = index_r;
          out_drop_nxt  = overflow_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tick_rate_r   <= ilm_pkg::TICK_RATE_RST;
      ptr_bytes_r   <= ilm_pkg::PTR_BYTES_RST;
      tick_sum_r    <= '0;
      event_count_r <= '0;
      max_ticks_r   <= '0;
      worst_addr_r  <= '0;
      range_count_r <= '0;
      overflow_r    <= 1'b0;
      launched_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      tick_sum_r    <= tick_sum_nxt;
      event_count_r <= event_count_nxt;
      max_ticks_r   <= max_ticks_nxt;
      worst_addr_r  <= worst_addr_nxt;
      range_count_r <= range_count_nxt;
      overflow_r    <= overflow_nxt;
      launched_r    <= launched_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we && cfg_index == ilm_pkg::CFG_TICK_RATE) begin
        tick_rate_r <= cfg_data;
      end
      if (cfg_we && cfg_index == ilm_pkg::CFG_PTR_BYTES) begin
        ptr_bytes_r <= cfg_data[ilm_pkg::PTR_BYTES_W-1:0];
      end
    end
  end

  // Query working values and the output register.
  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    max_us_r    <= max_us_nxt;
    avg_us_r    <= avg_us_nxt;
    scan_idx_r  <= scan_idx_nxt;
    found_r     <= found_nxt;
    index_r     <= index_nxt;
    out_avail_r <= out_avail_nxt;
    out_max_r   <= out_max_nxt;
    out_avg_r   <= out_avg_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.available      = out_avail_r;
  assign out_ch.lat_max        = out_max_r;
  assign out_ch.lat_avg        = out_avg_r;
  assign out_ch.driver_found   = out_found_r;
  assign out_ch.driver_index   = out_index_r;
  assign out_ch.images_dropped = out_drop_r;

  // The table fill count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    range_count_r <= CW'(IMAGE_SLOTS))
    else $error("image table count beyond slot count");

  // The overflow flag only rises once the table is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(overflow_r) |-> (range_count_r == CW'(IMAGE_SLOTS)))
    else $error("overflow flag set with free table slots");

  // A result only appears out of the final query state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the final query state");

  // The shared unit is quiet whenever new items are taken.
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !md_rsp.busy)
    else $error("arithmetic unit busy while taking items");

  // An accepted query leaves the idle state.
  a_query_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.kind == ilm_pkg::KIND_QUERY) |=> (state_r != ST_IDLE))
    else $error("query accepted without starting");

endmodule
